FILE: sv/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: sv/hse_pkg.sv
package hse_pkg;

	localparam int MAX_DIM = 10;
	localparam int VERT_W = MAX_DIM;
	localparam int DIM_W = 4;
	localparam int K_W = $clog2(MAX_DIM + 1);
	localparam int LEN_W = 10;
	localparam int NEW_W = 4;
	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(8);

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_EXTEND = 2'd1,
		OP_PROBE = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TEST,
		ST_CHECK,
		ST_NBR,
		ST_UPDATE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic ready;
		logic clear;
		logic test_rd;
		logic check;
		logic nbr;
		logic update;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic step_ok;
		logic nbr_last;
		logic out_busy;
	} sts_t;

	// dimension in use: zero counts as one, anything above the maximum as the maximum
	function automatic logic [K_W-1:0] active_dim(input logic [DIM_W-1:0] d);
		logic [K_W-1:0] r;
		if (d == '0) begin
			r = K_W'(1);
		end else if (int'(d) > MAX_DIM) begin
			r = K_W'(MAX_DIM);
		end else begin
			r = K_W'(d);
		end
		return r;
	endfunction

	// neighbour across one bit
	function automatic logic [VERT_W-1:0] flip(input logic [VERT_W-1:0] v,
			input logic [DIM_W-1:0] b);
		return v ^ (VERT_W'(1) << b);
	endfunction

	// 2^dim - 1, kept to the count width
	function automatic logic [VERT_W-1:0] full_count(input logic [K_W-1:0] d);
		logic [VERT_W:0] p;
		p = (VERT_W+1)'(1) << d;
		return VERT_W'(p - (VERT_W+1)'(1));
	endfunction

	localparam logic [VERT_W-1:0] CNT_RESET = full_count(active_dim(DIM_RESET));

endpackage

FILE: sv/hse_item_if.sv
interface hse_item_if;
	logic valid;
	logic ready;
	logic [1:0] opcode;
	logic [hse_pkg::DIM_W-1:0] step_dimension;

	modport source(output valid, output opcode, output step_dimension, input ready);
	modport sink(input valid, input opcode, input step_dimension, output ready);
endinterface

FILE: sv/hse_result_if.sv
interface hse_result_if;
	logic valid;
	logic ready;
	logic accepted;
	logic [hse_pkg::VERT_W-1:0] head_out;
	logic [hse_pkg::VERT_W-1:0] unmarked_out;
	logic [hse_pkg::LEN_W-1:0] length_out;
	logic [hse_pkg::NEW_W-1:0] newly_marked_out;

	modport source(output valid, output accepted, output head_out, output unmarked_out,
		output length_out, output newly_marked_out, input ready);
	modport sink(input valid, input accepted, input head_out, input unmarked_out,
		input length_out, input newly_marked_out, output ready);
endinterface

FILE: sv/hse_cfg_if.sv
interface hse_cfg_if;
	logic valid;
	logic ready;
	logic [hse_pkg::DIM_W-1:0] cube_dimension;

	modport source(output valid, output cube_dimension, input ready);
	modport sink(input valid, input cube_dimension, output ready);
endinterface

FILE: sv/hypercube_snake_extender.sv
// hypercube snake extender: grows an induced path on a hypercube of 1 to 10 dimensions
// (register cube_dimension, reset 8; 0 acts as 1, above 10 as 10). one result transaction
// follows every input transaction. opcode 0 starts a new snake at vertex 0, 1 extends the
// head across bit step_dimension if that neighbour is unmarked, 2 only probes the same test,
// 3 changes nothing. a vertex mark memory of 1024 x 1 bit is read and written one entry a
// cycle. an extend passes through the idle cycle that takes it, the step test read and its
// check, the neighbour reads and a drain cycle, the update and the result load; a probe
// goes from the check to the result load and an unused opcode straight from idle to it.
// a start sweeps the whole mark memory, one entry a cycle; the same sweep runs after reset,
// and no input transaction is taken during it (configuration writes are). the result sits
// in an output register, so the next input transaction is taken while a result still waits;
// the block stalls only when a second result is ready before the first has gone. write the
// configuration only while idle.
module hypercube_snake_extender (
	input logic clk,
	input logic arst_n,
	hse_item_if.sink item,
	hse_result_if.source result,
	hse_cfg_if.sink cfg
);

	hse_pkg::cmd_t cmd;
	hse_pkg::sts_t sts;
	logic item_take;
	logic cfg_take;

	// input transaction only in the idle state of the controller
	assign item.ready = cmd.ready;
	assign item_take = item.valid && cmd.ready;

	// the dimension register takes a write whenever offered
	assign cfg.ready = 1'b1;
	assign cfg_take = cfg.valid;

	// sequencer: sweep, step test, neighbour marking, update, result load
	hse_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.item_take(item_take),
		.item_op(item.opcode),
		.sts(sts),
		.cmd(cmd)
	);

	// mark memory, snake state and output register
	hse_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.item_take(item_take),
		.item_op(item.opcode),
		.item_dim(item.step_dimension),
		.cfg_take(cfg_take),
		.cfg_dim(cfg.cube_dimension),
		.res_ready(result.ready),
		.res_valid(result.valid),
		.res_accepted(result.accepted),
		.res_head(result.head_out),
		.res_unmarked(result.unmarked_out),
		.res_length(result.length_out),
		.res_newly(result.newly_marked_out)
	);

endmodule

FILE: sv/hse_ctrl.sv
module hse_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic item_take,
	input  logic [1:0] item_op,
	input  hse_pkg::sts_t sts,
	output hse_pkg::cmd_t cmd
);

	hse_pkg::state_t state_q, state_d;
	logic from_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hse_pkg::ST_CLEAR;
			from_item_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (item_take && item_op == hse_pkg::OP_START) begin
				from_item_q <= 1'b1;
			end else if (state_q == hse_pkg::ST_CLEAR && sts.clear_last) begin
				from_item_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			hse_pkg::ST_CLEAR: begin
				if (sts.clear_last) begin
					state_d = from_item_q ? hse_pkg::ST_DONE : hse_pkg::ST_IDLE;
				end
			end
			hse_pkg::ST_IDLE: begin
				if (item_take) begin
					case (item_op)
						hse_pkg::OP_START: state_d = hse_pkg::ST_CLEAR;
						hse_pkg::OP_EXTEND, hse_pkg::OP_PROBE: state_d = hse_pkg::ST_TEST;
						default: state_d = hse_pkg::ST_DONE;
					endcase
				end
			end
			hse_pkg::ST_TEST: state_d = hse_pkg::ST_CHECK;
			hse_pkg::ST_CHECK: begin
				state_d = sts.step_ok ? hse_pkg::ST_NBR : hse_pkg::ST_DONE;
			end
			hse_pkg::ST_NBR: begin
				if (sts.nbr_last) begin
					state_d = hse_pkg::ST_UPDATE;
				end
			end
			hse_pkg::ST_UPDATE: state_d = hse_pkg::ST_DONE;
			hse_pkg::ST_DONE: begin
				if (!sts.out_busy) begin
					state_d = hse_pkg::ST_IDLE;
				end
			end
			default: state_d = hse_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			hse_pkg::ST_CLEAR: cmd.clear = 1'b1;
			hse_pkg::ST_IDLE: cmd.ready = 1'b1;
			hse_pkg::ST_TEST: cmd.test_rd = 1'b1;
			hse_pkg::ST_CHECK: cmd.check = 1'b1;
			hse_pkg::ST_NBR: cmd.nbr = 1'b1;
			hse_pkg::ST_UPDATE: cmd.update = 1'b1;
			hse_pkg::ST_DONE: cmd.load_out = !sts.out_busy;
			default: cmd = '0;
		endcase
	end

endmodule

FILE: sv/hse_datapath.sv
`include "assert_macros.svh"

module hse_datapath (
	input  logic clk,
	input  logic arst_n,
	input  hse_pkg::cmd_t cmd,
	output hse_pkg::sts_t sts,
	input  logic item_take,
	input  logic [1:0] item_op,
	input  logic [hse_pkg::DIM_W-1:0] item_dim,
	input  logic cfg_take,
	input  logic [hse_pkg::DIM_W-1:0] cfg_dim,
	input  logic res_ready,
	output logic res_valid,
	output logic res_accepted,
	output logic [hse_pkg::VERT_W-1:0] res_head,
	output logic [hse_pkg::VERT_W-1:0] res_unmarked,
	output logic [hse_pkg::LEN_W-1:0] res_length,
	output logic [hse_pkg::NEW_W-1:0] res_newly
);

	localparam int DEPTH = 2 ** hse_pkg::VERT_W;

	logic [hse_pkg::DIM_W-1:0] dim_q;
	logic [hse_pkg::K_W-1:0] dim_act;

	logic [1:0] op_q;
	logic [hse_pkg::DIM_W-1:0] d_q;
	logic [hse_pkg::VERT_W-1:0] head_q;
	logic [hse_pkg::LEN_W-1:0] len_q;
	logic [hse_pkg::VERT_W-1:0] cnt_q;
	logic acc_q;
	logic [hse_pkg::NEW_W-1:0] fresh_q;

	logic [hse_pkg::K_W-1:0] k_q;
	logic pend_q;
	logic [hse_pkg::VERT_W-1:0] pend_addr_q;
	logic [hse_pkg::VERT_W-1:0] clr_addr_q;

	logic marks_mem [DEPTH];
	logic mark_rd_q;
	logic rd_en;
	logic [hse_pkg::VERT_W-1:0] rd_addr;
	logic wr_en;
	logic [hse_pkg::VERT_W-1:0] wr_addr;
	logic wr_data;
	logic k_active;
	logic fresh_hit;
	logic step_ok;

	logic out_valid_q;
	logic out_acc_q;
	logic [hse_pkg::VERT_W-1:0] out_head_q;
	logic [hse_pkg::VERT_W-1:0] out_cnt_q;
	logic [hse_pkg::LEN_W-1:0] out_len_q;
	logic [hse_pkg::NEW_W-1:0] out_new_q;

	assign dim_act = hse_pkg::active_dim(dim_q);
	assign k_active = cmd.nbr && (k_q < dim_act);
	assign fresh_hit = cmd.nbr && pend_q && !mark_rd_q;
	assign step_ok = (int'(d_q) < int'(dim_act)) && !mark_rd_q;

	// read port: target of the step, or the next neighbour
	assign rd_en = cmd.test_rd || k_active;
	assign rd_addr = cmd.test_rd ? hse_pkg::flip(head_q, d_q)
		: hse_pkg::flip(head_q, hse_pkg::DIM_W'(k_q));

	// write port: clearing sweep, or marking the neighbour read last cycle
	assign wr_en = cmd.clear || fresh_hit;
	assign wr_addr = cmd.clear ? clr_addr_q : pend_addr_q;
	assign wr_data = cmd.clear ? (clr_addr_q == '0) : 1'b1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			marks_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			mark_rd_q <= marks_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= hse_pkg::DIM_RESET;
		end else if (cfg_take) begin
			dim_q <= cfg_dim;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			len_q <= '0;
			cnt_q <= hse_pkg::CNT_RESET;
			clr_addr_q <= '0;
			k_q <= '0;
			pend_q <= 1'b0;
			fresh_q <= '0;
			acc_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_addr_q <= clr_addr_q + hse_pkg::VERT_W'(1);
			end
			if (item_take) begin
				k_q <= '0;
				pend_q <= 1'b0;
				fresh_q <= '0;
				acc_q <= (item_op == hse_pkg::OP_START);
				if (item_op == hse_pkg::OP_START) begin
					head_q <= '0;
					len_q <= '0;
					cnt_q <= hse_pkg::full_count(dim_act);
				end
			end
			if (cmd.check) begin
				acc_q <= step_ok;
			end
			if (cmd.nbr) begin
				pend_q <= k_active;
				if (k_active) begin
					k_q <= k_q + hse_pkg::K_W'(1);
				end
				if (fresh_hit) begin
					fresh_q <= fresh_q + hse_pkg::NEW_W'(1);
				end
			end
			if (cmd.update) begin
				// count saturates at zero after a mid-snake dimension raise
				cnt_q <= (cnt_q > hse_pkg::VERT_W'(fresh_q))
					? cnt_q - hse_pkg::VERT_W'(fresh_q) : '0;
				head_q <= hse_pkg::flip(head_q, d_q);
				len_q <= len_q + hse_pkg::LEN_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			op_q <= item_op;
			d_q <= item_dim;
		end
		if (k_active) begin
			pend_addr_q <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_acc_q <= acc_q;
			out_head_q <= head_q;
			out_cnt_q <= cnt_q;
			out_len_q <= len_q;
			out_new_q <= fresh_q;
		end
	end

	assign sts.clear_last = (clr_addr_q == '1);
	assign sts.step_ok = step_ok && (op_q == hse_pkg::OP_EXTEND);
	assign sts.nbr_last = (k_q == dim_act);
	assign sts.out_busy = out_valid_q && !res_ready;

	assign res_valid = out_valid_q;
	assign res_accepted = out_acc_q;
	assign res_head = out_head_q;
	assign res_unmarked = out_cnt_q;
	assign res_length = out_len_q;
	assign res_newly = out_new_q;

	`ASSERT_CLK(a_no_overwrite, cmd.load_out |-> !(out_valid_q && !res_ready), "result overwritten while waiting")
	`ASSERT_CLK(a_fresh_bound, int'(fresh_q) <= hse_pkg::MAX_DIM, "more new marks than neighbours")
	`ASSERT_CLK(a_len_only_update, (!cmd.update && !item_take) |=> $stable(len_q), "length moved outside an extend")
	`ASSERT_ALWAYS(a_k_bound, int'(k_q) <= hse_pkg::MAX_DIM, "neighbour counter past the dimension")

endmodule
